// ===== sv/sfrc_pkg.sv =====
package sfrc_pkg;

  // Default frame length in bytes, header and checksum included.
  localparam int unsigned FRAME_SIZE_DEF = 203;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned STAT_W = 2;

  // Header byte values.
  localparam logic [BYTE_W-1:0] PREAMBLE_POLL = 8'h71;
  localparam logic [BYTE_W-1:0] DIR_BYTE      = 8'h01;
  localparam logic [BYTE_W-1:0] CAT_STANDARD  = 8'h10;
  localparam logic [BYTE_W-1:0] CAT_EXTRA     = 8'h21;
  // Header bytes not counted by the length byte.
  localparam int unsigned HEADER_EXTRA = 3;

  // Header positions.
  localparam logic [POS_W-1:0] POS_PREAMBLE = 9'd0;
  localparam logic [POS_W-1:0] POS_LENGTH   = 9'd1;
  localparam logic [POS_W-1:0] POS_DIR      = 9'd2;
  localparam logic [POS_W-1:0] POS_CAT      = 9'd3;

  // Per-byte status reported with each echoed byte.
  typedef enum logic [STAT_W-1:0] {
    ST_DISCARD = 2'd0,
    ST_MID     = 2'd1,
    ST_GOOD    = 2'd2,
    ST_BAD     = 2'd3
  } frame_status_t;

endpackage

// ===== sv/sfrc_if.sv =====
// Channel carrying one received byte.
interface sfrc_in_if;
  import sfrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel carrying one echoed byte with its position and status.
interface sfrc_out_if;
  import sfrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  byte_position;
  logic [STAT_W-1:0] frame_status;

  modport source (output valid, output data_byte, output byte_position,
                  output frame_status, input ready);
  modport sink   (input valid, input data_byte, input byte_position,
                  input frame_status, output ready);
endinterface

// ===== sv/serial_frame_receiver_checksum.sv =====
// Serial frame receiver with header and checksum check.
// in_chan carries one received byte per transfer (valid/ready). out_chan
// returns every byte once, echoed with its position in the frame and a
// status: discarded, accepted mid-frame, frame complete with good sum, or
// frame complete with bad sum. Header positions 0 to 3 are checked; a wrong
// header byte drops the partial frame, and restarts it if it is a preamble.
// A frame of FRAME_SIZE bytes is good when its bytes sum to zero mod 256.
// A byte taken into the input register is checked on its way into the
// result register and shows on out_chan from there. Throughput is one byte
// per cycle while out_chan does not stall, set by the input register, the
// check logic and the result register forming a two-stage pipeline with a
// single update of the frame count and sum per byte.
// Reset (rst_n low, synchronous) empties both stages and clears the frame
// count and sum. When out_chan stalls, the result register holds its byte;
// the input register takes one more byte only if it is empty; after that
// in_chan.ready stays low until the result is transferred.
module serial_frame_receiver_checksum #(
  parameter int unsigned FRAME_SIZE = sfrc_pkg::FRAME_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfrc_in_if.sink    in_chan,
  sfrc_out_if.source out_chan
);
  import sfrc_pkg::*;

  sfrc_in_if  in_q ();
  sfrc_out_if res ();

  // Input register.
  sfrc_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_chan),
    .dn    (in_q)
  );

  // Header check, frame count and running sum.
  sfrc_frame_ctl #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_frame_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_q),
    .dn    (res)
  );

  // Result register.
  sfrc_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (res),
    .dn    (out_chan)
  );

endmodule

// ===== sv/sfrc_in_reg.sv =====
module sfrc_in_reg (
  input  logic  clk,
  input  logic  rst_n,
  sfrc_in_if.sink   up,
  sfrc_in_if.source dn
);
  import sfrc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // The register takes a new byte when empty or when its byte moves on.
  assign up.ready = !valid_r || dn.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (up.ready) begin
      valid_nxt = up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (up.ready && up.valid) begin
      byte_r <= up.rx_byte;
    end
  end

  assign dn.valid   = valid_r;
  assign dn.rx_byte = byte_r;

endmodule

// ===== sv/sfrc_frame_ctl.sv =====
module sfrc_frame_ctl #(
  parameter int unsigned FRAME_SIZE = sfrc_pkg::FRAME_SIZE_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sfrc_in_if.sink    up,
  sfrc_out_if.source dn
);
  import sfrc_pkg::*;

  localparam logic [POS_W-1:0] FS_W     = POS_W'(FRAME_SIZE);
  localparam logic [POS_W-1:0] LEN_BYTE = POS_W'(FRAME_SIZE - HEADER_EXTRA);

  logic [POS_W-1:0]  held_r;
  logic [POS_W-1:0]  held_nxt;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] sum_nxt;

  logic [POS_W-1:0]  held_base;
  logic [BYTE_W-1:0] sum_base;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  held_inc;
  logic [BYTE_W-1:0] sum_inc;
  logic              hdr_ok;
  logic              is_preamble;
  frame_status_t     status;
  logic              xfer;

  // Header check for the byte's position; body bytes always pass.
  function automatic logic header_ok(input logic [POS_W-1:0] p,
                                     input logic [BYTE_W-1:0] b);
    logic ok;
    ok = 1'b1;
    unique case (p)
      POS_PREAMBLE: ok = (b == PREAMBLE_POLL);
      POS_LENGTH:   ok = ({1'b0, b} == LEN_BYTE);
      POS_DIR:      ok = (b == DIR_BYTE);
      POS_CAT:      ok = (b == CAT_STANDARD) || (b == CAT_EXTRA);
      default:      ok = 1'b1;
    endcase
    return ok;
  endfunction

  // Purely a transform stage: the byte passes straight to the result register.
  assign up.ready = dn.ready;
  assign dn.valid = up.valid;
  assign xfer     = up.valid && dn.ready;

  // A completed frame is emptied before the next byte is checked.
  always_comb begin
    held_base = held_r;
    sum_base  = sum_r;
    if (held_r >= FS_W) begin
      held_base = '0;
      sum_base  = '0;
    end
  end

  assign hdr_ok      = header_ok(held_base, up.rx_byte);
  assign is_preamble = (up.rx_byte == PREAMBLE_POLL);

  // A wrong header byte drops the partial frame; a preamble restarts it.
  always_comb begin
    pos      = held_base;
    held_inc = held_base + POS_W'(1);
    sum_inc  = sum_base + up.rx_byte;
    if (!hdr_ok) begin
      pos      = '0;
      held_inc = POS_W'(1);
      sum_inc  = up.rx_byte;
    end
  end

  // Status and next frame state.
  always_comb begin
    held_nxt = held_inc;
    sum_nxt  = sum_inc;
    status   = ST_MID;
    if (!hdr_ok && !is_preamble) begin
      status   = ST_DISCARD;
      held_nxt = '0;
      sum_nxt  = '0;
    end else if (held_inc < FS_W) begin
      status = ST_MID;
    end else if (sum_inc == '0) begin
      status = ST_GOOD;
    end else begin
      status   = ST_BAD;
      held_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      sum_r  <= '0;
    end else if (xfer) begin
      held_r <= held_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign dn.data_byte     = up.rx_byte;
  assign dn.byte_position = (status == ST_DISCARD) ? '0 : pos;
  assign dn.frame_status  = status;

endmodule

// ===== sv/sfrc_out_reg.sv =====
module sfrc_out_reg (
  input  logic  clk,
  input  logic  rst_n,
  sfrc_out_if.sink   up,
  sfrc_out_if.source dn
);
  import sfrc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;
  logic [STAT_W-1:0] stat_r;

  // Load a new result when empty or when the held one is transferred.
  assign up.ready = !valid_r || dn.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (up.ready) begin
      valid_nxt = up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up.ready && up.valid) begin
      byte_r <= up.data_byte;
      pos_r  <= up.byte_position;
      stat_r <= up.frame_status;
    end
  end

  assign dn.valid         = valid_r;
  assign dn.data_byte     = byte_r;
  assign dn.byte_position = pos_r;
  assign dn.frame_status  = stat_r;

endmodule
